// ----- rtl/core/mains_phase_fire_and_rate_counter_assert.svh -----
// assertion macros for the phase fire and rate counter
`ifndef MAINS_PHASE_FIRE_AND_RATE_COUNTER_ASSERT_SVH
`define MAINS_PHASE_FIRE_AND_RATE_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MPFRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpfrc: implication check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MPFRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpfrc: next-cycle check failed");

`endif

// ----- rtl/core/mpfrc_pkg.sv -----
package mpfrc_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned TIMER_WIDTH = 16;
  localparam int unsigned LOAD_COUNT  = 6;
  localparam int unsigned DELAY_WIDTH = 16;
  localparam int unsigned RATE_WIDTH  = 16;
  localparam int unsigned IMP_WIDTH   = 16;

  localparam logic [IMP_WIDTH-1:0] IMPULSE_RESET = IMP_WIDTH'(100);

  // firing phase of the triac gate
  typedef enum logic [1:0] {
    PH_OFF,
    PH_WAIT,
    PH_IMPULSE
  } phase_e;

  // one input word as held in the input register
  typedef struct packed {
    logic                   mains_level;
    logic                   sonar_level;
    logic                   tacho_level;
    logic                   second_strobe;
    logic [DELAY_WIDTH-1:0] fire_delay;
    logic [LOAD_COUNT-1:0]  load_request;
  } in_word_t;

  // saturating increment of an edge count
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH-1:0] r;
    if (c == {COUNT_WIDTH{1'b1}}) begin
      r = c;
    end else begin
      r = c + COUNT_WIDTH'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mpfrc_if.sv -----
// input channel: sampled pins, strobe, delay and load request
interface mpfrc_in_if;
  import mpfrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   mains_level;
  logic                   sonar_level;
  logic                   tacho_level;
  logic                   second_strobe;
  logic [DELAY_WIDTH-1:0] fire_delay;
  logic [LOAD_COUNT-1:0]  load_request;

  modport source (
    output valid, mains_level, sonar_level, tacho_level, second_strobe,
           fire_delay, load_request,
    input  ready
  );

  modport sink (
    input  valid, mains_level, sonar_level, tacho_level, second_strobe,
           fire_delay, load_request,
    output ready
  );
endinterface

// output channel: gate, loads and published rates
interface mpfrc_out_if;
  import mpfrc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  motor_gate;
  logic [LOAD_COUNT-1:0] load_drive;
  logic [RATE_WIDTH-1:0] sonar_rate;
  logic [RATE_WIDTH-1:0] tacho_rate;
  logic [RATE_WIDTH-1:0] mains_rate;

  modport source (
    output valid, motor_gate, load_drive, sonar_rate, tacho_rate, mains_rate,
    input  ready
  );

  modport sink (
    input  valid, motor_gate, load_drive, sonar_rate, tacho_rate, mains_rate,
    output ready
  );
endinterface

// ----- rtl/core/mains_phase_fire_and_rate_counter.sv -----
// an accepted word enters the input register, then steps into the result registers
// throughput: one word per cycle unless out_o.ready stalls; the input register
//   and the result register (gate, load and rate state) form a two-stage pipeline
// reset: rst_ni async active low; pins, counts, rates, gate and loads clear,
//   phase off, impulse length register returns to 100
module mains_phase_fire_and_rate_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpfrc_pkg::IMP_WIDTH-1:0] cfg_wdata_i,
  mpfrc_in_if.sink                       in_i,
  mpfrc_out_if.source                    out_o
);
  import mpfrc_pkg::*;

  logic                   in_impulse;
  logic [IMP_WIDTH-1:0]   imp_len_q;

  logic                   s1_valid_q;
  in_word_t               s1_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   step;

  logic                   mains_prev_q, mains_prev_d;
  logic                   sonar_prev_q, sonar_prev_d;
  logic                   tacho_prev_q, tacho_prev_d;
  logic [COUNT_WIDTH-1:0] sonar_cnt_q, sonar_cnt_d;
  logic [COUNT_WIDTH-1:0] tacho_cnt_q, tacho_cnt_d;
  logic [COUNT_WIDTH-1:0] mains_cnt_q, mains_cnt_d;
  logic [COUNT_WIDTH-1:0] sonar_pub_q, sonar_pub_d;
  logic [COUNT_WIDTH-1:0] tacho_pub_q, tacho_pub_d;
  logic [COUNT_WIDTH-1:0] mains_pub_q, mains_pub_d;
  phase_e                 phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [TIMER_WIDTH-1:0] timer_dec;
  logic [TIMER_WIDTH-1:0] imp_len;
  logic                   gate_q, gate_d;
  logic [LOAD_COUNT-1:0]  load_q, load_d;

  // impulse length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imp_len_q <= IMPULSE_RESET;
    end else if (cfg_we_i) begin
      imp_len_q <= cfg_wdata_i;
    end
  end

  // pipeline control
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = advance && s1_valid_q;
  assign in_i.ready = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.mains_level   <= in_i.mains_level;
      s1_q.sonar_level   <= in_i.sonar_level;
      s1_q.tacho_level   <= in_i.tacho_level;
      s1_q.second_strobe <= in_i.second_strobe;
      s1_q.fire_delay    <= in_i.fire_delay;
      s1_q.load_request  <= in_i.load_request;
    end
  end

  assign timer_dec  = timer_q - TIMER_WIDTH'(1);
  assign imp_len    = TIMER_WIDTH'(imp_len_q);
  assign in_impulse = (phase_q == PH_IMPULSE);

  // per-tick state update
  always_comb begin
    mains_prev_d = mains_prev_q;
    sonar_prev_d = sonar_prev_q;
    tacho_prev_d = tacho_prev_q;
    sonar_cnt_d  = sonar_cnt_q;
    tacho_cnt_d  = tacho_cnt_q;
    mains_cnt_d  = mains_cnt_q;
    sonar_pub_d  = sonar_pub_q;
    tacho_pub_d  = tacho_pub_q;
    mains_pub_d  = mains_pub_q;
    phase_d      = phase_q;
    timer_d      = timer_q;
    gate_d       = gate_q;
    load_d       = load_q;

    if (step) begin
      // sonar and tacho edge counts
      if (s1_q.sonar_level != sonar_prev_q) begin
        sonar_cnt_d  = sat_inc(sonar_cnt_q);
        sonar_prev_d = s1_q.sonar_level;
      end
      if (s1_q.tacho_level != tacho_prev_q) begin
        tacho_cnt_d  = sat_inc(tacho_cnt_q);
        tacho_prev_d = s1_q.tacho_level;
      end

      // zero crossing restarts the firing cycle
      if (s1_q.mains_level != mains_prev_q) begin
        mains_prev_d = s1_q.mains_level;
        gate_d       = 1'b0;
        load_d       = s1_q.load_request;
        mains_cnt_d  = sat_inc(mains_cnt_q);
        timer_d      = TIMER_WIDTH'(s1_q.fire_delay);
        phase_d      = (TIMER_WIDTH'(s1_q.fire_delay) != '0) ? PH_WAIT : PH_OFF;
      end else begin
        unique case (phase_q)
          PH_WAIT: begin
            timer_d = timer_dec;
            if (timer_dec == '0) begin
              if (imp_len != '0) begin
                gate_d  = 1'b1;
                timer_d = imp_len;
                phase_d = PH_IMPULSE;
              end else begin
                gate_d  = 1'b0;
                phase_d = PH_OFF;
              end
            end
          end
          PH_IMPULSE: begin
            timer_d = timer_dec;
            if (timer_dec == '0) begin
              gate_d  = 1'b0;
              phase_d = PH_OFF;
            end
          end
          default: begin
            phase_d = PH_OFF;
            gate_d  = 1'b0;
            timer_d = '0;
          end
        endcase
      end

      // publish and clear on the second strobe
      if (s1_q.second_strobe) begin
        sonar_pub_d = sonar_cnt_d;
        tacho_pub_d = tacho_cnt_d;
        mains_pub_d = mains_cnt_d;
        sonar_cnt_d = '0;
        tacho_cnt_d = '0;
        mains_cnt_d = '0;
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mains_prev_q <= 1'b0;
      sonar_prev_q <= 1'b0;
      tacho_prev_q <= 1'b0;
      sonar_cnt_q  <= '0;
      tacho_cnt_q  <= '0;
      mains_cnt_q  <= '0;
      sonar_pub_q  <= '0;
      tacho_pub_q  <= '0;
      mains_pub_q  <= '0;
      phase_q      <= PH_OFF;
      timer_q      <= '0;
      gate_q       <= 1'b0;
      load_q       <= '0;
    end else begin
      mains_prev_q <= mains_prev_d;
      sonar_prev_q <= sonar_prev_d;
      tacho_prev_q <= tacho_prev_d;
      sonar_cnt_q  <= sonar_cnt_d;
      tacho_cnt_q  <= tacho_cnt_d;
      mains_cnt_q  <= mains_cnt_d;
      sonar_pub_q  <= sonar_pub_d;
      tacho_pub_q  <= tacho_pub_d;
      mains_pub_q  <= mains_pub_d;
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      gate_q       <= gate_d;
      load_q       <= load_d;
    end
  end

  // result word
  assign out_o.valid      = out_valid_q;
  assign out_o.motor_gate = gate_q;
  assign out_o.load_drive = load_q;
  assign out_o.sonar_rate = RATE_WIDTH'(sonar_pub_q);
  assign out_o.tacho_rate = RATE_WIDTH'(tacho_pub_q);
  assign out_o.mains_rate = RATE_WIDTH'(mains_pub_q);

  // checks
`include "mains_phase_fire_and_rate_counter_assert.svh"

  `MPFRC_ASSERT_IMP(a_gate_only_in_impulse, gate_q, in_impulse)
  `MPFRC_ASSERT_IMP(a_full_stall_blocks_input, s1_valid_q && !advance, !in_i.ready)
  `MPFRC_ASSERT_NXT(a_crossing_latches_loads,
    step && (s1_q.mains_level != mains_prev_q),
    (load_q == $past(s1_q.load_request)) && !gate_q)

endmodule

// ----- tb/sv/mpfrc_tb_pkg.sv -----
`timescale 1ns / 100ps
package mpfrc_tb_pkg;
  import mpfrc_pkg::*;

  // one output word: gate, loads and published rates
  typedef struct packed {
    logic                  motor_gate;
    logic [LOAD_COUNT-1:0] load_drive;
    logic [RATE_WIDTH-1:0] sonar_rate;
    logic [RATE_WIDTH-1:0] tacho_rate;
    logic [RATE_WIDTH-1:0] mains_rate;
  } drive_word_t;

  class phase_fire_checker;
    // predicted block state
    logic [IMP_WIDTH-1:0]   pulse_len;
    logic                   mains_prev;
    logic                   sonar_prev;
    logic                   tacho_prev;
    logic [COUNT_WIDTH-1:0] sonar_cnt;
    logic [COUNT_WIDTH-1:0] tacho_cnt;
    logic [COUNT_WIDTH-1:0] mains_cnt;
    logic [COUNT_WIDTH-1:0] sonar_pub;
    logic [COUNT_WIDTH-1:0] tacho_pub;
    logic [COUNT_WIDTH-1:0] mains_pub;
    phase_e                 phase;
    logic [TIMER_WIDTH-1:0] timer;
    logic                   gate;
    logic [LOAD_COUNT-1:0]  loads;

    drive_word_t expected_drive_q[$];
    int unsigned n_checked;
    int unsigned n_bad;
    int unsigned n_fires;
    int unsigned n_strobes;

    function new();
      pulse_len  = IMPULSE_RESET;
      mains_prev = 1'b0;
      sonar_prev = 1'b0;
      tacho_prev = 1'b0;
      sonar_cnt  = '0;
      tacho_cnt  = '0;
      mains_cnt  = '0;
      sonar_pub  = '0;
      tacho_pub  = '0;
      mains_pub  = '0;
      phase      = PH_OFF;
      timer      = '0;
      gate       = 1'b0;
      loads      = '0;
      n_checked  = 0;
      n_bad      = 0;
      n_fires    = 0;
      n_strobes  = 0;
    endfunction

    function void set_pulse_len(logic [IMP_WIDTH-1:0] v);
      pulse_len = v;
    endfunction

    function int unsigned pending();
      return expected_drive_q.size();
    endfunction

    // edge counts stick at all ones
    function logic [COUNT_WIDTH-1:0] count_up(logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    // advance the prediction by one tick and queue the expected word
    function void note_word(in_word_t w);
      drive_word_t exp;
      logic        gate_was;
      gate_was = gate;

      if (w.sonar_level != sonar_prev) begin
        sonar_cnt  = count_up(sonar_cnt);
        sonar_prev = w.sonar_level;
      end
      if (w.tacho_level != tacho_prev) begin
        tacho_cnt  = count_up(tacho_cnt);
        tacho_prev = w.tacho_level;
      end

      // zero crossing restarts the firing cycle
      if (w.mains_level != mains_prev) begin
        mains_prev = w.mains_level;
        gate       = 1'b0;
        loads      = w.load_request;
        mains_cnt  = count_up(mains_cnt);
        timer      = TIMER_WIDTH'(w.fire_delay);
        phase      = (TIMER_WIDTH'(w.fire_delay) != 0) ? PH_WAIT : PH_OFF;
      end else begin
        case (phase)
          PH_WAIT: begin
            timer = timer - 1'b1;
            if (timer == 0) begin
              if (TIMER_WIDTH'(pulse_len) != 0) begin
                gate  = 1'b1;
                timer = TIMER_WIDTH'(pulse_len);
                phase = PH_IMPULSE;
              end else begin
                gate  = 1'b0;
                phase = PH_OFF;
              end
            end
          end
          PH_IMPULSE: begin
            timer = timer - 1'b1;
            if (timer == 0) begin
              gate  = 1'b0;
              phase = PH_OFF;
            end
          end
          default: begin
            phase = PH_OFF;
            gate  = 1'b0;
            timer = '0;
          end
        endcase
      end

      // publish after counting this tick's edges
      if (w.second_strobe) begin
        sonar_pub = sonar_cnt;
        tacho_pub = tacho_cnt;
        mains_pub = mains_cnt;
        sonar_cnt = '0;
        tacho_cnt = '0;
        mains_cnt = '0;
        n_strobes++;
      end

      if (gate && !gate_was) n_fires++;

      exp.motor_gate = gate;
      exp.load_drive = loads;
      exp.sonar_rate = RATE_WIDTH'(sonar_pub);
      exp.tacho_rate = RATE_WIDTH'(tacho_pub);
      exp.mains_rate = RATE_WIDTH'(mains_pub);
      expected_drive_q.push_back(exp);
    endfunction

    function void report_bad(string what, logic [63:0] exp_v, logic [63:0] got_v);
      n_bad++;
      if (n_bad <= 10) begin
        $display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
      end
    endfunction

    // compare one output word with the oldest prediction
    function void check_drive(drive_word_t got);
      drive_word_t exp;
      if (expected_drive_q.size() == 0) begin
        report_bad("output word with nothing pending", '0, 64'(got));
        return;
      end
      exp = expected_drive_q.pop_front();
      n_checked++;
      if (got.motor_gate !== exp.motor_gate) begin
        report_bad("motor_gate", 64'(exp.motor_gate), 64'(got.motor_gate));
      end
      if (got.load_drive !== exp.load_drive) begin
        report_bad("load_drive", 64'(exp.load_drive), 64'(got.load_drive));
      end
      if (got.sonar_rate !== exp.sonar_rate) begin
        report_bad("sonar_rate", 64'(exp.sonar_rate), 64'(got.sonar_rate));
      end
      if (got.tacho_rate !== exp.tacho_rate) begin
        report_bad("tacho_rate", 64'(exp.tacho_rate), 64'(got.tacho_rate));
      end
      if (got.mains_rate !== exp.mains_rate) begin
        report_bad("mains_rate", 64'(exp.mains_rate), 64'(got.mains_rate));
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import mpfrc_pkg::*;
  import mpfrc_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [IMP_WIDTH-1:0] cfg_wdata_i;

  mpfrc_in_if  in_bus();
  mpfrc_out_if out_bus();

  phase_fire_checker sb = new();

  bit          steady;
  int unsigned stall_cycles;
  int unsigned n_sent;
  logic        mains_pin;
  logic        sonar_pin;
  logic        tacho_pin;

  mains_phase_fire_and_rate_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    out_bus.ready <= steady || ($urandom_range(0, 99) >= 7);
  end

  // monitors: check before noting so an early word cannot match a fresh prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_drive('{motor_gate: out_bus.motor_gate, load_drive: out_bus.load_drive,
                         sonar_rate: out_bus.sonar_rate, tacho_rate: out_bus.tacho_rate,
                         mains_rate: out_bus.mains_rate});
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_word('{mains_level: in_bus.mains_level, sonar_level: in_bus.sonar_level,
                       tacho_level: in_bus.tacho_level, second_strobe: in_bus.second_strobe,
                       fire_delay: in_bus.fire_delay, load_request: in_bus.load_request});
      end
      // watchdog on handshake progress
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("mains_phase_fire_and_rate_counter: mismatch");
        $finish;
      end
    end
  end

  function automatic in_word_t pins(logic m, logic s, logic t, logic st,
                                    logic [DELAY_WIDTH-1:0] d, logic [LOAD_COUNT-1:0] l);
    in_word_t w;
    w.mains_level   = m;
    w.sonar_level   = s;
    w.tacho_level   = t;
    w.second_strobe = st;
    w.fire_delay    = d;
    w.load_request  = l;
    return w;
  endfunction

  // present one word and hold it until taken
  task automatic send_word(input in_word_t w);
    if (!steady && $urandom_range(0, 99) < 7) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid         <= 1'b1;
    in_bus.mains_level   <= w.mains_level;
    in_bus.sonar_level   <= w.sonar_level;
    in_bus.tacho_level   <= w.tacho_level;
    in_bus.second_strobe <= w.second_strobe;
    in_bus.fire_delay    <= w.fire_delay;
    in_bus.load_request  <= w.load_request;
    do @(posedge clk_i); while (!in_bus.ready);
    n_sent++;
  endtask

  // stop sending and wait for every predicted word
  task automatic drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_pulse_len(input logic [IMP_WIDTH-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_pulse_len(v);
  endtask

  // mains toggling at random half periods with occasional glitches
  task automatic run_random(input int unsigned n_items);
    in_word_t    w;
    int unsigned gap;
    gap = $urandom_range(2, 40);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (gap == 0) begin
        mains_pin = ~mains_pin;
        gap = ($urandom_range(0, 99) < 5) ? 1 : $urandom_range(2, 40);
      end
      gap--;
      if ($urandom_range(0, 99) < 25) sonar_pin = ~sonar_pin;
      if ($urandom_range(0, 99) < 25) tacho_pin = ~tacho_pin;
      w = pins(mains_pin, sonar_pin, tacho_pin, $urandom_range(0, 49) == 0, '0,
               LOAD_COUNT'($urandom));
      case ($urandom_range(0, 9))
        0:       w.fire_delay = '0;
        1, 2:    w.fire_delay = DELAY_WIDTH'($urandom);
        default: w.fire_delay = DELAY_WIDTH'($urandom_range(1, 30));
      endcase
      send_word(w);
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    steady               = 1'b0;
    stall_cycles         = 0;
    n_sent               = 0;
    mains_pin            = 1'b0;
    sonar_pin            = 1'b0;
    tacho_pin            = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.mains_level   = 1'b0;
    in_bus.sonar_level   = 1'b0;
    in_bus.tacho_level   = 1'b0;
    in_bus.second_strobe = 1'b0;
    in_bus.fire_delay    = '0;
    in_bus.load_request  = '0;
    out_bus.ready        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, default impulse length
    // first sample at 1 is a crossing and an edge on both sonar and tacho
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'd3, 6'h3F));
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF, 6'h00));
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 6'h00));
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 6'h00));
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 6'h00));
    // crossing with zero delay never fires
    send_word(pins(1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 6'h00));
    send_word(pins(1'b0, 1'b1, 1'b1, 1'b0, 16'd5, 6'h3F));
    // strobe with an edge on the same tick, then a bare strobe
    send_word(pins(1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 6'h00));
    send_word(pins(1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 6'h00));
    // longest delay, then cut short by a new crossing
    send_word(pins(1'b1, 1'b0, 1'b0, 1'b0, 16'hFFFF, 6'h2A));
    send_word(pins(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 6'h00));
    send_word(pins(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 6'h00));
    // shortest delay fires on the next tick
    send_word(pins(1'b0, 1'b0, 1'b0, 1'b0, 16'd1, 6'h15));
    send_word(pins(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 6'h00));
    // crossing during the pulse drops the gate
    send_word(pins(1'b1, 1'b1, 1'b0, 1'b0, 16'd2, 6'h00));
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 6'h00));
    send_word(pins(1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 6'h00));
    send_word(pins(1'b1, 1'b0, 1'b1, 1'b1, 16'h8000, 6'h00));
    send_word(pins(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 6'h3F));
    mains_pin = 1'b0;
    sonar_pin = 1'b0;
    tacho_pin = 1'b1;

    // random phases over several impulse lengths
    write_pulse_len(IMP_WIDTH'(1));
    run_random(400);
    write_pulse_len('1);
    run_random(300);
    write_pulse_len(IMP_WIDTH'($urandom_range(2, 20)));
    run_random(250);
    drain();
    run_random(250);
    write_pulse_len(IMP_WIDTH'(3));
    steady = 1'b1;
    run_random(300);
    steady = 1'b0;
    write_pulse_len(IMP_WIDTH'(100));
    run_random(400);

    drain();
    repeat (4) @(posedge clk_i);
    $display("checked %0d of %0d words: %0d gate pulses, %0d strobes, %0d bad fields",
             sb.n_checked, n_sent, sb.n_fires, sb.n_strobes, sb.n_bad);
    $display("impulse lengths 1 to 65535, glitchy mains and a stretch with no stalls");
    if (sb.n_bad == 0) begin
      $display("mains_phase_fire_and_rate_counter: match");
    end else begin
      $display("mains_phase_fire_and_rate_counter: mismatch");
    end
    $finish;
  end

endmodule
